// ----- sv/rgii_pkg.sv -----
package rgii_pkg;

  typedef enum logic [1:0] {
    CFG_SPIN_THRESHOLD = 2'd0,
    CFG_HORIZ_MAG_THRESHOLD = 2'd1,
    CFG_LOWPASS_GAIN = 2'd2,
    CFG_STUCK_COUNT_LIMIT = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQRT,
    ST_FILT,
    ST_VMUL,
    ST_VDIV,
    ST_VADD,
    ST_PMUL,
    ST_PDIV,
    ST_PADD,
    ST_FIN,
    ST_OUT
  } state_e;

  localparam logic signed [31:0] GQ16 = 32'sd642908;
  localparam logic [33:0] VEL_DIV = 34'd8192000000;
  localparam logic [20:0] POS_DIV = 21'd2000000;
  localparam logic signed [31:0] ONE_M = 32'sd65536;
  localparam logic signed [31:0] THROW_MIN = 32'sd196608;

endpackage

// ----- sv/rest_gated_inertial_integrator.sv -----
// Channel   | Direction | Content
// cfg       | in        | cfg_index_i register index, cfg_data_i 16-bit value
// s_axis    | in        | accel_x, accel_y, accel_z, gyro_z, elapsed_us
// m_axis    | out       | spinning, at_rest, velocities, positions, throw data
//
// One item at a time. The square root and then the serial filter multiply run
// first. At rest the velocities clear one axis at a time; otherwise each axis
// takes a serial multiply, a bit-serial division and an add, and while spinning
// the position steps repeat them per axis. Velocity and position steps share
// one divider. Reset clears the state machine, filter and motion state and
// restores register defaults. The result waits in the output register;
// s_axis_tready is low until it has been taken, and the next item can be
// accepted in the cycle after.
module rest_gated_inertial_integrator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_z[63:48], elapsed_us[83:64]
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // spinning[0], at_rest[1], vel_x..vel_z[97:2], pos_x,pos_y[161:98],
  // pos_z[192:162], throw_done[193], throw_peak[224:194]
  output logic [231:0] m_axis_tdata
);
  import rgii_pkg::*;

  state_e state_q, state_d;
  logic signed [15:0] spin_thr_q;
  logic [15:0] mag_thr_q, gain_q, limit_q;
  logic spin_now_q, spin_bef_q, rest_q;
  logic signed [31:0] vel_q [3];
  logic signed [31:0] vold_q [3];
  logic signed [31:0] pos_q [3];
  logic signed [15:0] prev_q [3];
  logic signed [15:0] acc_q [3];
  logic [19:0] us_q;
  logic [15:0] filt_q, stuck_q;
  logic [31:0] mag_q;
  logic signed [31:0] peak_q;
  logic [31:0] rad_q;
  logic [31:0] bit_q;
  logic [4:0] cnt_q;
  logic [1:0] ax_q;
  logic signed [63:0] prod_q;
  logic [63:0] mcand_q;
  logic [31:0] mplier_q;
  logic neg_q;
  logic [231:0] out_q;
  logic div_start;
  logic [63:0] div_num;
  logic [33:0] div_den;
  logic div_busy;
  logic [63:0] div_quo;

  rgii_serdiv u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .quo_o(div_quo)
  );

  assign cfg_ready_o = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata = out_q;

  // Signed floor(p/d) from the unsigned quotient: for a negative numerator the
  // divider sees -p + d - 1.
  logic signed [63:0] q_s;
  logic signed [64:0] sum65;
  logic signed [31:0] sat32;
  assign q_s = neg_q ? -$signed(div_quo) : $signed(div_quo);
  always_comb begin
    if (state_q == ST_VADD) sum65 = 65'(vel_q[ax_q]) + 65'(q_s);
    else sum65 = 65'(pos_q[ax_q]) + 65'(q_s);
    if (sum65 > 65'sd2147483647) sat32 = 32'h7fffffff;
    else if (sum65 < -65'sd2147483648) sat32 = 32'h80000000;
    else sat32 = sum65[31:0];
  end

  // Filter update, done once in ST_FILT after the serial product is ready.
  logic signed [47:0] fnew;
  logic [15:0] fsat;
  logic [15:0] stuck_n;
  logic rest_n;
  always_comb begin
    fnew = 48'(signed'({1'b0, filt_q})) + 48'(prod_q >>> 16);
    if (fnew < 0) fsat = 16'd0;
    else if (fnew > 48'sd65535) fsat = 16'hffff;
    else fsat = fnew[15:0];
    if (mag_q < mag_thr_q && fsat > mag_thr_q)
      stuck_n = (stuck_q == 16'hffff) ? stuck_q : stuck_q + 16'd1;
    else stuck_n = 16'd0;
    if (stuck_n > limit_q) fsat = 16'd0;
    rest_n = !spin_now_q && fsat < mag_thr_q;
  end

  // Numerator signs and magnitudes for the divider.
  logic signed [63:0] vnum, pnum;
  always_comb begin
    vnum = prod_q + 64'sd4096000000;
    pnum = prod_q + 64'sd1000000;
    div_start = 1'b0;
    div_num = '0;
    div_den = VEL_DIV;
    if (state_q == ST_VMUL && cnt_q == 5'd0) begin
      div_start = 1'b1;
      div_num = vnum[63] ? 64'(-vnum + 64'(VEL_DIV) - 64'd1) : vnum;
    end else if (state_q == ST_PMUL && cnt_q == 5'd0) begin
      div_start = 1'b1;
      div_den = 34'(POS_DIV);
      div_num = pnum[63] ? 64'(-pnum + 64'(POS_DIV) - 64'd1) : pnum;
    end
    if (state_q == ST_PMUL || state_q == ST_PDIV) div_den = 34'(POS_DIV);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (s_axis_tvalid) state_d = ST_SQRT;
      ST_SQRT: if (bit_q == 32'd0) state_d = ST_FILT;
      ST_FILT: if (cnt_q == 5'd0) state_d = rest_n ? ST_VADD : ST_VMUL;
      ST_VMUL: if (cnt_q == 5'd0) state_d = ST_VDIV;
      ST_VDIV: if (!div_busy) state_d = ST_VADD;
      ST_VADD: begin
        if (ax_q != 2'd2) state_d = rest_q ? ST_VADD : ST_VMUL;
        else state_d = spin_now_q ? ST_PMUL : ST_FIN;
      end
      ST_PMUL: if (cnt_q == 5'd0) state_d = ST_PDIV;
      ST_PDIV: if (!div_busy) state_d = ST_PADD;
      ST_PADD: state_d = (ax_q != 2'd2) ? ST_PMUL : ST_FIN;
      ST_FIN: state_d = ST_OUT;
      ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      spin_thr_q <= '0;
      mag_thr_q <= 16'd410;
      gain_q <= 16'd6554;
      limit_q <= 16'd10;
      spin_now_q <= 1'b0;
      spin_bef_q <= 1'b0;
      filt_q <= '0;
      stuck_q <= '0;
      peak_q <= '0;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        pos_q[i] <= '0;
        prev_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SPIN_THRESHOLD: spin_thr_q <= cfg_data_i;
          CFG_HORIZ_MAG_THRESHOLD: mag_thr_q <= cfg_data_i;
          CFG_LOWPASS_GAIN: gain_q <= cfg_data_i;
          CFG_STUCK_COUNT_LIMIT: limit_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == ST_IDLE && s_axis_tvalid) begin
        spin_bef_q <= spin_now_q;
        spin_now_q <= $signed(s_axis_tdata[63:48]) > spin_thr_q;
      end
      if (state_q == ST_FILT && cnt_q == 5'd0) begin
        filt_q <= fsat;
        stuck_q <= stuck_n;
      end
      if (state_q == ST_VADD) begin
        vel_q[ax_q] <= rest_q ? 32'sd0 : sat32;
      end
      if (state_q == ST_PADD) begin
        pos_q[ax_q] <= sat32;
      end
      if (state_q == ST_FIN) begin
        for (int i = 0; i < 3; i++) prev_q[i] <= acc_q[i];
        if (spin_now_q) begin
          if (pos_q[2] > peak_q) peak_q <= pos_q[2];
          if (pos_q[2] < 0) pos_q[2] <= '0;
        end else if (rest_q) begin
          pos_q[0] <= '0;
          pos_q[1] <= '0;
          pos_q[2] <= ONE_M;
        end
        if (!spin_now_q && spin_bef_q && peak_q > THROW_MIN) peak_q <= '0;
      end
    end
  end

  // Datapath: serial shift-add multiplier, square-root digits, axis index.
  // The root register is full width because the partial root runs up to 2^30.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        acc_q[0] <= s_axis_tdata[15:0];
        acc_q[1] <= s_axis_tdata[31:16];
        acc_q[2] <= s_axis_tdata[47:32];
        us_q <= s_axis_tdata[83:64];
        rad_q <= 32'($signed(s_axis_tdata[15:0]) * $signed(s_axis_tdata[15:0]))
               + 32'($signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]));
        bit_q <= 32'h40000000;
        mag_q <= '0;
        ax_q <= '0;
      end
      ST_SQRT: begin
        if (bit_q != 0) begin
          if (rad_q >= mag_q + bit_q) begin
            rad_q <= rad_q - (mag_q + bit_q);
            mag_q <= (mag_q >> 1) + bit_q;
          end else begin
            mag_q <= mag_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end else begin
          mcand_q <= 64'($signed({1'b0, mag_q}) - $signed({1'b0, filt_q}));
          mplier_q <= 32'(gain_q);
          prod_q <= '0;
          cnt_q <= 5'd16;
        end
      end
      ST_FILT, ST_VMUL, ST_PMUL: begin
        if (cnt_q != 0) begin
          if (mplier_q[0]) prod_q <= prod_q + $signed(mcand_q);
          mcand_q <= mcand_q << 1;
          mplier_q <= mplier_q >> 1;
          cnt_q <= cnt_q - 5'd1;
        end else begin
          neg_q <= (state_q == ST_VMUL) ? vnum[63] : pnum[63];
        end
        if (state_q == ST_FILT && cnt_q == 0) begin
          rest_q <= rest_n;
          mcand_q <= 64'($signed(acc_q[0]) + $signed(prev_q[0])) * 64'(GQ16);
          mplier_q <= 32'(us_q);
          prod_q <= '0;
          cnt_q <= 5'd20;
        end
      end
      ST_VADD: begin
        vold_q[ax_q] <= vel_q[ax_q];
        if (ax_q != 2'd2) begin
          ax_q <= ax_q + 2'd1;
          mcand_q <= 64'($signed(acc_q[ax_q + 2'd1]) + $signed(prev_q[ax_q + 2'd1]))
                   * 64'(GQ16);
          cnt_q <= 5'd20;
        end else begin
          // The position steps start again at axis 0, whose new velocity is stored.
          ax_q <= '0;
          mcand_q <= 64'($signed(vel_q[0]) + $signed(vold_q[0]));
          cnt_q <= 5'd20;
        end
        mplier_q <= 32'(us_q);
        prod_q <= '0;
      end
      ST_PADD: begin
        if (ax_q != 2'd2) begin
          ax_q <= ax_q + 2'd1;
          mcand_q <= 64'($signed(vel_q[ax_q + 2'd1]) + $signed(vold_q[ax_q + 2'd1]));
        end
        mplier_q <= 32'(us_q);
        prod_q <= '0;
        cnt_q <= 5'd20;
      end
      default: ;
    endcase
  end

  // Final position and throw fields, computed from the state before ST_FIN updates it.
  logic signed [31:0] pz, pk;
  logic dn;
  always_comb begin
    pz = (spin_now_q && pos_q[2] < 0) ? 32'sd0 : pos_q[2];
    pk = (spin_now_q && pos_q[2] > peak_q) ? pos_q[2] : peak_q;
    dn = !spin_now_q && spin_bef_q && peak_q > THROW_MIN;
    if (!spin_now_q && rest_q) pz = ONE_M;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FIN) begin
      out_q <= {7'd0,
                dn ? pk[30:0] : 31'd0,
                dn,
                pz[30:0],
                (!spin_now_q && rest_q) ? 32'sd0 : pos_q[1],
                (!spin_now_q && rest_q) ? 32'sd0 : pos_q[0],
                vel_q[2],
                vel_q[1],
                vel_q[0],
                rest_q,
                spin_now_q};
    end
  end
endmodule

// ----- sv/rgii_serdiv.sv -----
// Restoring division of a non-negative dividend by a constant, one quotient bit per cycle.
module rgii_serdiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [33:0] den_i,
  output logic        busy_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d;
  logic [34:0] rem_q, rem_d;
  logic [6:0]  cnt_q, cnt_d;
  logic [34:0] sh;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    sh = '0;
    if (start_i) begin
      quo_d = num_i;
      rem_d = '0;
      cnt_d = 7'd64;
    end else if (cnt_q != 7'd0) begin
      sh = {rem_q[33:0], quo_q[63]};
      if (sh >= {1'b0, den_i}) begin
        rem_d = sh - {1'b0, den_i};
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = sh;
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign busy_o = (cnt_q != 7'd0);
  assign quo_o = quo_q;
endmodule

// ----- sv/rgii_checker.sv -----
module rgii_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [231:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped while stalled");
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open while result pending");
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[193] |-> m_axis_tdata[224:194] == 31'd0)
    else $error("peak without throw");
  a_rest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> !m_axis_tdata[0]) else $error("rest while spinning");
endmodule

bind rest_gated_inertial_integrator rgii_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tready, .m_axis_tvalid, .m_axis_tready,
  .m_axis_tdata
);

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rgii_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [1:0]   cfg_index_i = '0;
  logic [15:0]  cfg_data_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [87:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [231:0] m_axis_tdata;

  // One inertial sample as it enters the block.
  typedef struct packed {
    logic [19:0]        elapsed_us;
    logic signed [15:0] gyro_z;
    logic signed [15:0] accel_z;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_x;
  } sample_t;

  // One motion estimate as it leaves the block.
  typedef struct packed {
    logic               spinning;
    logic               at_rest;
    logic [2:0][31:0]   vel;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        pos_z;
    logic               throw_done;
    logic [30:0]        throw_peak;
  } estimate_t;

  // Directed row: a sample plus an optional typed-in expectation.
  typedef struct {
    sample_t   smp;
    logic      fixed;
    estimate_t want;
  } directed_row_t;

  rest_gated_inertial_integrator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the configuration registers.
  logic signed [15:0] spin_thr_q;
  logic [15:0]        mag_thr_q, lp_gain_q, stuck_lim_q;

  // Shadow of the motion state.
  logic               spin_q, spin_prev_q;
  logic signed [31:0] vel_q[3], pos_q[3];
  logic signed [15:0] acc_prev_q[3];
  logic [15:0]        filt_q, stuck_q;
  logic signed [31:0] peak_q;

  estimate_t estimates_due[$];
  int        mismatches = 0;
  int        idle_pct_in = 0;
  int        stall_pct_out = 0;
  logic      stim_done = 1'b0;

  function automatic logic [15:0] int_sqrt(input logic [31:0] x);
    logic [31:0] r, b, v;
    r = 0; b = 32'h4000_0000; v = x;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[15:0];
  endfunction

  // Floor division for positive divisor.
  function automatic longint floor_div(input longint p, input longint d);
    if (p >= 0) return p / d;
    return -((-p + d - 1) / d);
  endfunction

  function automatic logic signed [31:0] sat_sum(input logic signed [31:0] a, input longint b);
    longint s;
    s = longint'(a) + b;
    if (s > 64'sd2147483647) return 32'sh7fff_ffff;
    if (s < -64'sd2147483648) return 32'sh8000_0000;
    return s[31:0];
  endfunction

  task automatic reset_motion_state();
    spin_thr_q = 0; mag_thr_q = 410; lp_gain_q = 6554; stuck_lim_q = 10;
    spin_q = 0; spin_prev_q = 0;
    for (int i = 0; i < 3; i++) begin
      vel_q[i] = 0; pos_q[i] = 0; acc_prev_q[i] = 0;
    end
    filt_q = 0; stuck_q = 0; peak_q = 0;
  endtask

  // Advances the shadow state by one sample and returns the estimate.
  function automatic estimate_t integrate_sample(input sample_t s);
    estimate_t          e;
    logic signed [15:0] acc[3];
    logic signed [31:0] v_old[3];
    longint             us, p, f;
    logic [31:0]        sq;
    logic [15:0]        mag;
    logic               rest;
    acc[0] = s.accel_x; acc[1] = s.accel_y; acc[2] = s.accel_z;
    us = longint'(s.elapsed_us);
    spin_prev_q = spin_q;
    spin_q = s.gyro_z > spin_thr_q;
    sq = 32'(int'(acc[0]) * int'(acc[0])) + 32'(int'(acc[1]) * int'(acc[1]));
    mag = int_sqrt(sq);
    p = (longint'(mag) - longint'(filt_q)) * longint'(lp_gain_q);
    f = longint'(filt_q) + floor_div(p, 65536);
    if (f < 0) f = 0;
    if (f > 65535) f = 65535;
    filt_q = f[15:0];
    if (mag < mag_thr_q && filt_q > mag_thr_q) begin
      if (stuck_q != 16'hffff) stuck_q++;
    end else begin
      stuck_q = 0;
    end
    if (stuck_q > stuck_lim_q) filt_q = 0;
    rest = !spin_q && filt_q < mag_thr_q;
    for (int i = 0; i < 3; i++) begin
      v_old[i] = vel_q[i];
      if (rest) begin
        vel_q[i] = 0;
      end else begin
        p = longint'(int'(acc[i]) + int'(acc_prev_q[i])) * us * longint'(GQ16);
        vel_q[i] = sat_sum(vel_q[i], floor_div(p + 64'sd4096000000, 64'sd8192000000));
      end
    end
    if (spin_q) begin
      for (int i = 0; i < 3; i++) begin
        p = (longint'(vel_q[i]) + longint'(v_old[i])) * us;
        pos_q[i] = sat_sum(pos_q[i], floor_div(p + 1000000, 2000000));
      end
      if (pos_q[2] > peak_q) peak_q = pos_q[2];
      if (pos_q[2] < 0) pos_q[2] = 0;
    end else if (rest) begin
      pos_q[0] = 0; pos_q[1] = 0; pos_q[2] = ONE_M;
    end
    e.throw_done = 1'b0;
    e.throw_peak = '0;
    // A throw ends when the spin stops with the peak above the minimum height.
    if (!spin_q && spin_prev_q && peak_q > THROW_MIN) begin
      e.throw_done = 1'b1;
      e.throw_peak = peak_q[30:0];
      peak_q = 0;
    end
    for (int i = 0; i < 3; i++) acc_prev_q[i] = acc[i];
    e.spinning = spin_q;
    e.at_rest = rest;
    for (int i = 0; i < 3; i++) e.vel[i] = vel_q[i];
    e.pos_x = pos_q[0];
    e.pos_y = pos_q[1];
    e.pos_z = pos_q[2][30:0];
    return e;
  endfunction

  // Valid stays high after an item until the next item, an idle cycle or the drain.
  task automatic send_sample(input sample_t s);
    estimate_t e;
    while ($urandom_range(99) < idle_pct_in) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tdata <= {4'h0, s};
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    e = integrate_sample(s);
    estimates_due.push_back(e);
    @(negedge clk_i);
  endtask

  task automatic send_checked(input sample_t s, input estimate_t want);
    estimate_t got;
    send_sample(s);
    got = estimates_due[$];
    // Typed-in expectations must agree with the predictor too.
    if (got != want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("directed row disagrees: sample %h exp %p got %p", s, want, got);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (estimates_due.size() != 0) @(negedge clk_i);
    repeat (500) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_SPIN_THRESHOLD:      spin_thr_q = val;
      CFG_HORIZ_MAG_THRESHOLD: mag_thr_q = val;
      CFG_LOWPASS_GAIN:        lp_gain_q = val;
      default:                 stuck_lim_q = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic sample_t mk(input int ax, ay, az, gz, us);
    sample_t s;
    s.accel_x = 16'(ax); s.accel_y = 16'(ay); s.accel_z = 16'(az);
    s.gyro_z = 16'(gz); s.elapsed_us = 20'(us);
    return s;
  endfunction

  // Random sample: mostly throw-like sequences are built by the caller via gyro choice.
  function automatic sample_t rand_sample(input logic spin, input int reach);
    sample_t s;
    s.accel_x = 16'($urandom_range(reach) - reach / 2);
    s.accel_y = 16'($urandom_range(reach) - reach / 2);
    s.accel_z = 16'($urandom_range(reach) - reach / 2);
    s.gyro_z = spin ? 16'($urandom_range(32767, 1000)) : 16'($urandom_range(500) - 250);
    case ($urandom_range(9))
      0:       s.elapsed_us = 20'($urandom_range(20'hfffff));
      1:       s.elapsed_us = 0;
      default: s.elapsed_us = 20'($urandom_range(5000));
    endcase
    if ($urandom_range(19) == 0) s = 84'($urandom());
    if ($urandom_range(19) == 0) s.elapsed_us = 20'($urandom_range(20'hfffff));
    return s;
  endfunction

  // Output side: random stalls, sampling at the rising edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct_out);
  end

  always @(posedge clk_i) begin
    estimate_t want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.spinning = m_axis_tdata[0];
      got.at_rest = m_axis_tdata[1];
      got.vel[0] = m_axis_tdata[33:2];
      got.vel[1] = m_axis_tdata[65:34];
      got.vel[2] = m_axis_tdata[97:66];
      got.pos_x = m_axis_tdata[129:98];
      got.pos_y = m_axis_tdata[161:130];
      got.pos_z = m_axis_tdata[192:162];
      got.throw_done = m_axis_tdata[193];
      got.throw_peak = m_axis_tdata[224:194];
      if (estimates_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected estimate %h", m_axis_tdata);
      end else begin
        want = estimates_due.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("estimate mismatch: exp %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t r;
    estimate_t     e0;
    sample_t       s;
    int            phase_pct_in[4] = '{0, 80, 0, 27};
    int            phase_pct_out[4] = '{0, 0, 80, 27};
    reset_motion_state();
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // At rest after reset with zero input: zero velocity, position at one meter.
    e0.spinning = 0; e0.at_rest = 1;
    for (int i = 0; i < 3; i++) e0.vel[i] = 0;
    e0.pos_x = 0; e0.pos_y = 0; e0.pos_z = 31'd65536;
    e0.throw_done = 0; e0.throw_peak = 0;
    r.fixed = 1; r.want = e0; r.smp = mk(0, 0, 0, 0, 1000); rows.push_back(r);
    r.fixed = 0;
    r.smp = mk(32767, 32767, 32767, 32767, 20'hfffff); rows.push_back(r);
    r.smp = mk(-32768, -32768, -32768, 32767, 20'hfffff); rows.push_back(r);
    r.smp = mk(-32768, -32768, -32768, 32767, 20'hfffff); rows.push_back(r);
    r.smp = mk(0, 0, 32767, 20000, 100000); rows.push_back(r);
    r.smp = mk(0, 0, 32767, 20000, 100000); rows.push_back(r);
    r.smp = mk(0, 0, -32768, 20000, 100000); rows.push_back(r);
    // Spin stops: a throw ends here when the peak cleared the minimum height.
    r.smp = mk(0, 0, 0, -32768, 1000); rows.push_back(r);
    // Low raw magnitude while the filter stays high exercises the stuck reset.
    for (int k = 0; k < 4; k++) begin
      r.smp = mk(30000, 0, 0, 0, 100); rows.push_back(r);
    end
    for (int k = 0; k < 14; k++) begin
      r.smp = mk(0, 0, 0, 0, 100); rows.push_back(r);
    end
    r.smp = mk(0, 0, 0, 0, 0); rows.push_back(r);
    foreach (rows[i]) begin
      if (rows[i].fixed) send_checked(rows[i].smp, rows[i].want);
      else send_sample(rows[i].smp);
    end
    wait_drained();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct_in = phase_pct_in[ph];
      stall_pct_out = phase_pct_out[ph];
      case (ph)
        0: begin
          write_reg(CFG_SPIN_THRESHOLD, 16'h7fff);
          write_reg(CFG_HORIZ_MAG_THRESHOLD, 16'hffff);
          write_reg(CFG_LOWPASS_GAIN, 16'hffff);
          write_reg(CFG_STUCK_COUNT_LIMIT, 16'd0);
        end
        1: begin
          write_reg(CFG_SPIN_THRESHOLD, 16'h8000);
          write_reg(CFG_HORIZ_MAG_THRESHOLD, 16'd0);
          write_reg(CFG_LOWPASS_GAIN, 16'd0);
          write_reg(CFG_STUCK_COUNT_LIMIT, 16'hffff);
        end
        default: begin
          write_reg(CFG_SPIN_THRESHOLD, 16'd600);
          write_reg(CFG_HORIZ_MAG_THRESHOLD, 16'($urandom_range(2000, 200)));
          write_reg(CFG_LOWPASS_GAIN, 16'($urandom_range(30000, 2000)));
          write_reg(CFG_STUCK_COUNT_LIMIT, 16'($urandom_range(20, 1)));
        end
      endcase
      // Throw-shaped bursts: rest, spin with upward thrust, then release.
      for (int n = 0; n < 250; ) begin
        int len;
        len = $urandom_range(12, 2);
        for (int k = 0; k < len; k++, n++) send_sample(rand_sample(0, 400));
        len = $urandom_range(20, 2);
        for (int k = 0; k < len; k++, n++) begin
          s = rand_sample(1, 16000);
          if (k < len / 2) s.accel_z = 16'($urandom_range(32767, 8000));
          s.elapsed_us = 20'($urandom_range(60000, 1000));
          send_sample(s);
        end
      end
      wait_drained();
    end
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0 && estimates_due.size() == 0) begin
      $display("** rest_gated_inertial_integrator: PASSED **");
    end else begin
      $display("** rest_gated_inertial_integrator: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** rest_gated_inertial_integrator: FAILED **");
    $finish;
  end

endmodule
